### hw/rtl/sng_pkg.sv
// package: types, constants and codes for the spiking neuron group
`timescale 1ns / 1ps
package sng_pkg;

	localparam int NEURONS = 2;
	localparam int NW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
	localparam int WDEPTH = NEURONS * NEURONS;
	localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_WEIGHT = 2'd1,
		ACT_VOLT   = 2'd2,
		ACT_ADAPT  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_TARGET    = 3'd0,
		REG_THRESHOLD = 3'd1,
		REG_RESET_V   = 3'd2,
		REG_INCREMENT = 3'd3,
		REG_RETAIN    = 3'd4,
		REG_GAIN      = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [5:0]         neuron_index;
		logic [5:0]         target_index;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [5:0]         out_neuron;
		logic signed [31:0] out_voltage;
		logic [31:0]        out_adaptation;
		logic               spiked;
		logic               last_report;
	} out_item_t;

	// classified request passed from front to back
	typedef struct packed {
		action_t            act;
		logic [NW-1:0]      row;
		logic [NW-1:0]      col;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] target;
		logic signed [31:0] threshold;
		logic signed [31:0] reset_v;
		logic [31:0]        increment;
		logic [24:0]        retain;
		logic [31:0]        gain;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
		logic signed [31:0] r;
		if (x > 34'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -34'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/spiking_neuron_group_step.sv
// top level: config registers, front end, back end and result register
`timescale 1ns / 1ps
// A tick produces one report per neuron, in index order, with last_report on
// the final one; writes produce no report. A tick's time is set mostly by the
// bit-serial divider in the voltage step of each neuron, plus a weight read
// and add per target for each spiking neuron.
// The weight store needs no clearing pass: per-entry valid bits stand in.
module spiking_neuron_group_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  sng_pkg::in_item_t    in_item,
	output logic                 empty,
	input  logic                 pop,
	output sng_pkg::out_item_t   out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	sng_pkg::cfg_t cfg_q;
	logic cmd_valid, cmd_take, res_valid, res_ready, full_q;
	sng_pkg::cmd_t cmd;
	sng_pkg::out_item_t res, out_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target <= 32'sd3146;
			cfg_q.threshold <= 32'sd3041;
			cfg_q.reset_v <= 32'sd0;
			cfg_q.increment <= 32'd16777216;
			cfg_q.retain <= 25'd16760439;
			cfg_q.gain <= 32'd10485760;
		end else if (cfg_valid) begin
			unique case (sng_pkg::reg_index_t'(cfg_index))
				sng_pkg::REG_TARGET:    cfg_q.target <= cfg_data;
				sng_pkg::REG_THRESHOLD: cfg_q.threshold <= cfg_data;
				sng_pkg::REG_RESET_V:   cfg_q.reset_v <= cfg_data;
				sng_pkg::REG_INCREMENT: cfg_q.increment <= cfg_data;
				sng_pkg::REG_RETAIN:    cfg_q.retain <= cfg_data[24:0];
				sng_pkg::REG_GAIN:      cfg_q.gain <= cfg_data;
				default: ;
			endcase
		end
	end

	sng_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	sng_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd), .cfg(cfg_q), .res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	// output register
	assign res_ready = !full_q || pop;
	assign empty = !full_q;
	assign out_item = out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (res_ready) begin
			full_q <= res_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !cmd_take) |=> full) else $error("full queue emptied without a take");
	a_report_order: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && !res.last_report) |=> res_valid)
		else $error("report walk broken");
	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> !res_valid) else $error("result while taking request");
endmodule

### hw/rtl/sng_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module sng_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH>1?DEPTH:2)-1:0] addr,
	input  logic [WIDTH-1:0]                 wdata,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write or registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### hw/rtl/sng_front.sv
// front end: accepts actions, drops out-of-range writes, queues requests
`timescale 1ns / 1ps
module sng_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  sng_pkg::in_item_t   in_item,
	output logic                cmd_valid,
	input  logic                cmd_take,
	output sng_pkg::cmd_t       cmd
);
	localparam int QD = 2;
	sng_pkg::cmd_t q_q [QD];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic keep, acc;
	sng_pkg::cmd_t nc;

	assign full = (cnt_q == 2'(QD));
	assign acc = push && !full;

	// classify: ticks always kept, writes need valid indices
	always_comb begin
		nc.act = sng_pkg::action_t'(in_item.action);
		nc.row = in_item.neuron_index[sng_pkg::NW-1:0];
		nc.col = in_item.target_index[sng_pkg::NW-1:0];
		nc.value = in_item.value;
		unique case (nc.act)
			sng_pkg::ACT_TICK:   keep = 1'b1;
			sng_pkg::ACT_WEIGHT: keep = (32'(in_item.neuron_index) < 32'(sng_pkg::NEURONS))
				&& (32'(in_item.target_index) < 32'(sng_pkg::NEURONS));
			default:             keep = 32'(in_item.neuron_index) < 32'(sng_pkg::NEURONS);
		endcase
	end

	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rd_q];

	// request queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (acc && keep) begin
				wr_q <= !wr_q;
			end
			if (cmd_take) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(acc && keep) - 2'(cmd_take);
		end
	end

	always_ff @(posedge clk) begin
		if (acc && keep) begin
			q_q[wr_q] <= nc;
		end
	end
endmodule

### hw/rtl/sng_div.sv
// radix-2 restoring divider, 64 by 32 bits, quotient capped to 32 bits
`timescale 1ns / 1ps
module sng_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	logic [63:0] rem_q, quo_q;
	logic [31:0] d_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;

	assign trial = {rem_q[63:0], quo_q[63]} - {33'd0, d_q};

	// one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= 7'd0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 64'd0;
			quo_q <= dividend;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = (quo_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo_q[31:0];
endmodule

### hw/rtl/sng_back.sv
// back end: executes writes and walks the neurons on a tick
`timescale 1ns / 1ps
module sng_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_take,
	input  sng_pkg::cmd_t     cmd,
	input  sng_pkg::cfg_t     cfg,
	output logic              res_valid,
	input  logic              res_ready,
	output sng_pkg::out_item_t res
);
	localparam int NW = sng_pkg::NW;
	localparam int WAW = sng_pkg::WAW;

	typedef enum logic [3:0] {
		S_IDLE, S_PEND, S_DECAY, S_DIFF, S_MUL, S_DIV, S_STEP, S_CHECK,
		S_WRD, S_WADD, S_REP
	} state_t;

	state_t state_q;
	logic signed [31:0] v_q [sng_pkg::NEURONS];
	logic [31:0] k_q [sng_pkg::NEURONS];
	logic [sng_pkg::NEURONS-1:0] pend_q;
	logic [NW-1:0] i_q, j_q;
	logic [63:0] prod_q;
	logic [31:0] mag_q;
	logic neg_q;
	logic [31:0] step_q;
	logic div_start, div_done;
	logic [31:0] div_q;
	logic signed [31:0] vi, vj;
	logic [31:0] ki;
	logic [56:0] kprod;
	logic [32:0] ksum;
	logic signed [32:0] diff;
	logic ram_we;
	logic [WAW-1:0] ram_addr;
	logic [31:0] ram_rd, wgt;
	logic [NW:0] nxt;
	logic [sng_pkg::NEURONS*sng_pkg::NEURONS-1:0] wv_q;

	assign vi = v_q[i_q];
	assign vj = v_q[j_q];
	assign ki = k_q[i_q];
	assign kprod = {25'd0, ki} * {32'd0, cfg.retain} + 57'h80_0000;
	assign ksum = {1'b0, ki} + {1'b0, cfg.increment};
	assign diff = {cfg.target[31], cfg.target} - {vi[31], vi};

	// weight store with valid bits standing for the cleared reset state
	assign ram_we = (state_q == S_IDLE) && cmd_valid && (cmd.act == sng_pkg::ACT_WEIGHT);
	assign ram_addr = ram_we ? WAW'(32'(cmd.row) * sng_pkg::NEURONS + 32'(cmd.col))
		: WAW'(32'(i_q) * sng_pkg::NEURONS + 32'(j_q));
	sng_ram #(.WIDTH(32), .DEPTH(sng_pkg::NEURONS * sng_pkg::NEURONS)) u_wram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(cmd.value), .rdata(ram_rd)
	);
	logic wsel_q;
	assign wgt = wsel_q ? ram_rd : 32'd0;

	assign div_start = (state_q == S_MUL);
	sng_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(prod_q),
		.divisor(ki), .done(div_done), .quotient(div_q)
	);

	assign cmd_take = (state_q == S_IDLE) && cmd_valid;
	assign res_valid = (state_q == S_REP);
	assign nxt = {1'b0, i_q} + 1'b1;
	always_comb begin
		res.out_neuron = 6'(i_q);
		res.out_voltage = vi;
		res.out_adaptation = ki;
		res.spiked = pend_q[i_q];
		res.last_report = (32'(i_q) == sng_pkg::NEURONS - 1);
	end

	// neuron walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int n = 0; n < sng_pkg::NEURONS; n++) begin
				v_q[n] <= 32'sd0;
				k_q[n] <= 32'h0100_0000;
			end
			pend_q <= '0;
			wv_q <= '0;
			wsel_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			prod_q <= '0;
			mag_q <= '0;
			neg_q <= 1'b0;
			step_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd_valid) begin
					unique case (cmd.act)
						sng_pkg::ACT_TICK: begin
							i_q <= '0;
							state_q <= S_PEND;
						end
						sng_pkg::ACT_WEIGHT: wv_q[ram_addr] <= 1'b1;
						sng_pkg::ACT_VOLT: v_q[cmd.row] <= cmd.value;
						sng_pkg::ACT_ADAPT: k_q[cmd.row] <= cmd.value[31] ? 32'd0 : cmd.value;
					endcase
				end
				S_PEND: begin
					if (pend_q[i_q]) begin
						k_q[i_q] <= ksum[32] ? 32'hFFFF_FFFF : ksum[31:0];
						v_q[i_q] <= cfg.reset_v;
						pend_q[i_q] <= 1'b0;
					end
					state_q <= S_DECAY;
				end
				S_DECAY: begin
					k_q[i_q] <= (kprod[56:56] != 1'b0) ? 32'hFFFF_FFFF : kprod[55:24];
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					neg_q <= diff[32];
					mag_q <= diff[32] ? 32'(-diff) : diff[31:0];
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: if (div_done) begin
					step_q <= (mag_q == 0) ? 32'd0 : (ki == 0) ? 32'hFFFF_FFFF : div_q;
					state_q <= S_STEP;
				end
				S_STEP: begin
					v_q[i_q] <= neg_q ? sng_pkg::sat32(34'(vi) - 34'(step_q))
						: sng_pkg::sat32(34'(vi) + 34'(step_q));
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					j_q <= '0;
					if (vi >= cfg.threshold) begin
						pend_q[i_q] <= 1'b1;
						state_q <= S_WRD;
					end else if (32'(nxt) == sng_pkg::NEURONS) begin
						i_q <= '0;
						state_q <= S_REP;
					end else begin
						i_q <= NW'(nxt);
						state_q <= S_PEND;
					end
				end
				S_WRD: begin
					wsel_q <= wv_q[ram_addr];
					state_q <= S_WADD;
				end
				S_WADD: begin
					v_q[j_q] <= sng_pkg::sat32(34'(vj) + 34'($signed(wgt)));
					if (32'(j_q) == sng_pkg::NEURONS - 1) begin
						if (32'(nxt) == sng_pkg::NEURONS) begin
							i_q <= '0;
							state_q <= S_REP;
						end else begin
							i_q <= NW'(nxt);
							state_q <= S_PEND;
						end
					end else begin
						j_q <= NW'(32'(j_q) + 1);
						state_q <= S_WRD;
					end
				end
				S_REP: if (res_ready) begin
					if (32'(nxt) == sng_pkg::NEURONS) begin
						i_q <= '0;
						state_q <= S_IDLE;
					end else begin
						i_q <= NW'(nxt);
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// product registered before the divider starts
			if (state_q == S_DIFF) begin
				prod_q <= 64'(cfg.gain) * 64'(diff[32] ? 32'(-diff) : diff[31:0]);
			end
		end
	end
endmodule

### sim/sng_checker.sv
// checker: watches the block's channels, predicts every report and compares
`timescale 1ns / 1ps
module sng_checker
	import sng_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  logic      full,
	input  in_item_t  in_item,
	input  logic      empty,
	input  logic      pop,
	input  out_item_t out_item,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int        fail_count,
	output int        reports_due
);

	cfg_t               regs;
	logic signed [31:0] volt [NEURONS];
	logic [31:0]        adapt [NEURONS];
	bit                 pend [NEURONS];
	logic signed [31:0] weight [WDEPTH];
	out_item_t          report_q [$];

	assign reports_due = report_q.size();

	function automatic logic signed [31:0] clamp32(longint x);
		if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (x < -64'sd2147483648) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	// one neuron of the tick walk
	task automatic advance_neuron(int i);
		logic [63:0] s, k, mag, step;
		longint      diff, v;
		int          j;
		if (pend[i]) begin
			s = {32'd0, adapt[i]} + {32'd0, regs.increment};
			adapt[i] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
			volt[i] = regs.reset_v;
			pend[i] = 0;
		end
		k = ({32'd0, adapt[i]} * {39'd0, regs.retain} + 64'h80_0000) >> 24;
		if (k > 64'hFFFF_FFFF) k = 64'hFFFF_FFFF;
		adapt[i] = k[31:0];
		v = longint'(volt[i]);
		diff = longint'(regs.target) - v;
		mag = (diff < 0) ? -diff : diff;
		if (mag == 0) begin
			step = 0;
		end else if (k == 0) begin
			step = 64'hFFFF_FFFF;
		end else begin
			step = ({32'd0, regs.gain} * mag) / k;
			if (step > 64'hFFFF_FFFF) step = 64'hFFFF_FFFF;
		end
		v = (diff < 0) ? v - longint'(step) : v + longint'(step);
		volt[i] = clamp32(v);
		if (volt[i] >= regs.threshold) begin
			pend[i] = 1;
			for (j = 0; j < NEURONS; j++)
				volt[j] = clamp32(longint'(volt[j]) + longint'(weight[i * NEURONS + j]));
		end
	endtask

	// expected reports for one accepted request
	task automatic predict_reports(in_item_t it);
		out_item_t r;
		int        i;
		if (it.action == ACT_TICK) begin
			for (i = 0; i < NEURONS; i++) advance_neuron(i);
			for (i = 0; i < NEURONS; i++) begin
				r.out_neuron = 6'(i);
				r.out_voltage = volt[i];
				r.out_adaptation = adapt[i];
				r.spiked = pend[i];
				r.last_report = (i == NEURONS - 1);
				report_q.push_back(r);
			end
		end else if (it.neuron_index < NEURONS) begin
			case (it.action)
				ACT_WEIGHT: begin
					if (it.target_index < NEURONS)
						weight[it.neuron_index * NEURONS + it.target_index] = it.value;
				end
				ACT_VOLT: volt[it.neuron_index] = it.value;
				default: adapt[it.neuron_index] = (it.value < 0) ? 32'd0 : it.value;
			endcase
		end
	endtask

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// sample all channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			regs = '{target: 32'sd3146, threshold: 32'sd3041, reset_v: 32'sd0,
				increment: 32'd16777216, retain: 25'd16760439, gain: 32'd10485760};
			for (int i = 0; i < NEURONS; i++) begin
				volt[i] = 0;
				adapt[i] = 32'd16777216;
				pend[i] = 0;
			end
			for (int i = 0; i < WDEPTH; i++) weight[i] = 0;
			report_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TARGET:    regs.target = cfg_data;
					REG_THRESHOLD: regs.threshold = cfg_data;
					REG_RESET_V:   regs.reset_v = cfg_data;
					REG_INCREMENT: regs.increment = cfg_data;
					REG_RETAIN:    regs.retain = cfg_data[24:0];
					REG_GAIN:      regs.gain = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (report_q.size() == 0) begin
					$display("%0t unexpected report: expected none actual %0h", $time, out_item);
					fail_count++;
				end else begin
					e = report_q.pop_front();
					check_field("out_neuron", e.out_neuron, out_item.out_neuron);
					check_field("out_voltage", e.out_voltage, out_item.out_voltage);
					check_field("out_adaptation", e.out_adaptation, out_item.out_adaptation);
					check_field("spiked", e.spiked, out_item.spiked);
					check_field("last_report", e.last_report, out_item.last_report);
				end
			end
			if (push && !full) predict_reports(in_item);
		end
	end

endmodule

### sim/tb_top.sv
// testbench top: clock, reset, request stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module tb_top;
	import sng_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        full;
	in_item_t    in_item = '0;
	logic        empty;
	logic        pop = 0;
	out_item_t   out_item;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 0;
	logic [31:0] cfg_data = 0;
	int          fail_count;
	int          reports_due;

	int burst_left = 0;
	int hold_ask = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int pat_left = 0;
	int pat_mode = 0;
	int idle_cycles = 0;

	spiking_neuron_group_step dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sng_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .reports_due(reports_due)
	);

	always #5 clk = ~clk;

	// receiver: changing stall patterns, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 0;
		end else if (hold_seen != hold_ask) begin
			hold_seen <= hold_ask;
			hold_left <= 600;
			pop <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pop <= 0;
		end else begin
			if (pat_left == 0) begin
				pat_mode <= $urandom_range(0, 3);
				pat_left <= $urandom_range(20, 200);
			end else begin
				pat_left <= pat_left - 1;
			end
			case (pat_mode)
				0: pop <= 1;
				1: pop <= $urandom_range(0, 1);
				2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// offer one request, then possibly start a gap between bursts
	task automatic send_item(logic [1:0] act, logic [5:0] n, logic [5:0] t, logic [31:0] v);
		int gap;
		in_item <= '{action: act, neuron_index: n, target_index: t, value: v};
		push <= 1;
		@(posedge clk);
		while (full) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			gap = $urandom_range(1, 20);
			push <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait until every report is in; settle lets writes still in flight finish
	task automatic drain(bit settle);
		int guard;
		guard = 0;
		push <= 0;
		@(posedge clk);
		while (reports_due != 0) begin
			@(posedge clk);
			guard++;
			if (guard > 200000) begin
				$display("Regression FAIL");
				$finish;
			end
		end
		if (settle) repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic write_all(logic [31:0] tv, logic [31:0] th, logic [31:0] rv,
			logic [31:0] inc, logic [31:0] ret, logic [31:0] gn);
		drain(1);
		write_reg(REG_TARGET, tv);
		write_reg(REG_THRESHOLD, th);
		write_reg(REG_RESET_V, rv);
		write_reg(REG_INCREMENT, inc);
		write_reg(REG_RETAIN, ret);
		write_reg(REG_GAIN, gn);
	endtask

	function automatic logic [31:0] pick_voltage();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return $urandom_range(0, 16000) - 8000;
		endcase
	endfunction

	function automatic logic [31:0] pick_adapt();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 32'h8000_0000 | $urandom;
			2: return $urandom;
			3: return 32'h7FFF_FFFF;
			default: return $urandom_range(1 << 22, 1 << 26);
		endcase
	endfunction

	function automatic logic [5:0] pick_index();
		if ($urandom_range(0, 19) == 0) return $urandom_range(0, 63);
		return $urandom_range(0, NEURONS - 1);
	endfunction

	// mostly in-range traffic with plenty of ticks, some ignored writes
	task automatic random_items(int count);
		int sel;
		repeat (count) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)
				send_item(ACT_TICK, $urandom, $urandom, $urandom);
			else if (sel < 65)
				send_item(ACT_WEIGHT, pick_index(), pick_index(), pick_voltage());
			else if (sel < 82)
				send_item(ACT_VOLT, pick_index(), $urandom, pick_voltage());
			else
				send_item(ACT_ADAPT, pick_index(), $urandom, pick_adapt());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, zero and negative adaptation, ignored writes
		send_item(ACT_WEIGHT, 0, 1, 32'h7FFF_FFFF);
		send_item(ACT_WEIGHT, 1, 0, 32'h8000_0000);
		send_item(ACT_WEIGHT, 0, 0, -32'sd5000);
		send_item(ACT_TICK, 0, 0, 0);
		send_item(ACT_VOLT, 0, 0, 32'h7FFF_FFFF);
		send_item(ACT_VOLT, 1, 0, 32'h8000_0000);
		send_item(ACT_TICK, 63, 63, 32'hFFFF_FFFF);
		send_item(ACT_ADAPT, 0, 0, 0);
		send_item(ACT_TICK, 0, 0, 0);
		send_item(ACT_ADAPT, 1, 0, 32'h8000_0000);
		send_item(ACT_VOLT, 1, 0, 32'd3146);
		send_item(ACT_TICK, 0, 0, 0);
		send_item(ACT_VOLT, 63, 0, 32'h1234_5678);
		send_item(ACT_WEIGHT, 0, 63, 32'h1234_5678);
		send_item(ACT_WEIGHT, 42, 1, 32'h1234_5678);
		send_item(ACT_ADAPT, 2, 0, 32'h0100_0000);
		send_item(ACT_ADAPT, 0, 0, 32'h7FFF_FFFF);
		send_item(ACT_TICK, 0, 0, 0);
		send_item(ACT_WEIGHT, 1, 1, 32'd20000);
		send_item(ACT_TICK, 0, 0, 0);
		send_item(ACT_TICK, 0, 0, 0);

		// reset settings, with a long receiver hold-off
		random_items(150);
		hold_ask <= hold_ask + 1;
		random_items(180);

		write_all(32'd20000, 32'd15000, -32'sd3000, 32'd4194304, 32'd16000000, 32'd50000000);
		random_items(150);
		drain(0);
		random_items(150);

		write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h01FF_FFFF, 32'hFFFF_FFFF);
		random_items(300);

		write_all(0, 0, 0, 0, 0, 0);
		random_items(300);

		write_all(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, $urandom, 32'h0100_0000,
			$urandom);
		random_items(300);

		write_all($urandom_range(0, 8000), $urandom_range(0, 8000), $urandom, $urandom,
			$urandom_range(0, 33554431), $urandom_range(0, 1 << 28));
		random_items(400);

		drain(1);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
